### hdl/atan2_angle_unit_assert.svh
// assertion macros for the checker file
`ifndef ATAN2_ANGLE_UNIT_ASSERT_SVH
`define ATAN2_ANGLE_UNIT_ASSERT_SVH

// checked only while out of reset
`define ATAN_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ATAN_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/atan_pkg.sv
// shared constants, types and helpers of the atan2 angle unit
package atan_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int QF             = 30;
    localparam int QW             = QF + 1;
    localparam int XM_W           = 29;
    localparam int G_W            = 27;
    localparam int W_W            = 31;
    localparam int QM_W           = 36;
    localparam int XF_W           = 32;
    localparam int V_W            = 34;
    localparam int ANGLE_W        = 16;
    localparam int ANGLE_MAX      = 25736;

    localparam logic [63:0] QONE = 64'd1 << QF;

    // q30 constants rounded to nearest
    localparam logic [63:0] TAN15_C = (64'd2679491924 * QONE + 64'd10000000000 / 2)
                                      / 64'd10000000000;
    localparam logic [63:0] ROOT3_C = (64'd1732050808 * QONE + 64'd1000000000 / 2)
                                      / 64'd1000000000;
    localparam logic [63:0] P0_C    = (64'd1368876889 * QONE + 64'd100000000 / 2)
                                      / 64'd100000000;
    localparam logic [63:0] P1_C    = (64'd2050585520 * QONE + 64'd100000000 / 2)
                                      / 64'd100000000;
    localparam logic [63:0] P2_C    = (64'd8494624035 * QONE + 64'd1000000000 / 2)
                                      / 64'd1000000000;
    localparam logic [63:0] P3_C    = (64'd8375829937 * QONE + 64'd10000000000 / 2)
                                      / 64'd10000000000;
    localparam logic [63:0] Q0_C    = (64'd4106630668 * QONE + 64'd100000000 / 2)
                                      / 64'd100000000;
    localparam logic [63:0] Q1_C    = (64'd8615734960 * QONE + 64'd100000000 / 2)
                                      / 64'd100000000;
    localparam logic [63:0] Q2_C    = (64'd5957843614 * QONE + 64'd100000000 / 2)
                                      / 64'd100000000;
    localparam logic [63:0] Q3_C    = (64'd1502400116 * QONE + 64'd100000000 / 2)
                                      / 64'd100000000;
    localparam logic [63:0] PI_C    = (64'd3141592654 * QONE + 64'd1000000000 / 2)
                                      / 64'd1000000000;
    localparam logic [63:0] PI2_C   = (64'd1570796327 * QONE + 64'd1000000000 / 2)
                                      / 64'd1000000000;
    localparam logic [63:0] PI3_C   = (64'd1047197551 * QONE + 64'd1000000000 / 2)
                                      / 64'd1000000000;
    localparam logic [63:0] PI6_C   = (64'd5235987756 * QONE + 64'd10000000000 / 2)
                                      / 64'd10000000000;

    localparam logic [30:0] TAN15_K = TAN15_C[30:0];
    localparam logic [30:0] ROOT3_K = ROOT3_C[30:0];
    localparam logic [31:0] QONE_K  = QONE[31:0];
    localparam logic [29:0] P3_K    = P3_C[29:0];
    localparam logic [33:0] P2_K    = P2_C[33:0];
    localparam logic [34:0] P1_K    = P1_C[34:0];
    localparam logic [33:0] P0_K    = P0_C[33:0];
    localparam logic [33:0] Q3_K    = Q3_C[33:0];
    localparam logic [35:0] Q2_K    = Q2_C[35:0];
    localparam logic [36:0] Q1_K    = Q1_C[36:0];
    localparam logic [35:0] Q0_K    = Q0_C[35:0];

    localparam logic signed [V_W-1:0] PI_S  = $signed(PI_C[V_W-1:0]);
    localparam logic signed [V_W-1:0] PI2_S = $signed(PI2_C[V_W-1:0]);
    localparam logic signed [V_W-1:0] PI3_S = $signed(PI3_C[V_W-1:0]);
    localparam logic signed [V_W-1:0] PI6_S = $signed(PI6_C[V_W-1:0]);

    // per-item flags that ride along the pipeline
    typedef struct packed {
        logic xneg;
        logic yneg;
        logic x_zero;
        logic y_zero;
        logic swap;
        logic xform;
        logic rneg;
    } item_t;

    localparam int ITEM_W = $bits(item_t);

    // offset added after the octant polynomial
    function automatic logic signed [V_W-1:0] oct_offset(input logic [1:0] n);
        logic signed [V_W-1:0] r;
        unique case (n)
            2'd0: r = '0;
            2'd1: r = PI6_S;
            2'd2: r = PI2_S;
            2'd3: r = PI3_S;
        endcase
        return r;
    endfunction

endpackage

### hdl/atan2_angle_unit.sv
// throughput: one request per cycle; a stalled output only holds the stages that are full
// bubbles close up one stage per cycle; s_ready is high while the first stage is empty
// the three 31-stage dividers set the depth: one quotient bit per stage
// reset (aresetn low, synchronous) clears every stage valid bit; data registers keep garbage
module atan2_angle_unit import atan_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_x_coord,
    input  logic signed [COORD_BITS-1:0] s_y_coord,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [ANGLE_W-1:0]    m_angle
);

    logic                  en;
    logic                  prep_v, div1_rdy, div1_v, xf_rdy, xf_v, div2_rdy, div2_v;
    logic                  poly_rdy, poly_v, div3_rdy, div3_v, post_rdy;
    logic [COORD_BITS-1:0] lo, hi;
    item_t                 prep_f, div1_f, xf_f, poly_f;
    logic [ITEM_W-1:0]     div1_side;
    logic [QW-1:0]         t, xq, rq;
    logic [XF_W-1:0]       xf_num, xf_den;
    logic [XM_W-1:0]       xf_t, poly_xm;
    logic [ITEM_W+XM_W-1:0] div2_side, div3_side;
    logic [QM_W-1:0]       poly_num, poly_den;

    // whole pipe moves unless the output holds an untaken result
    assign en = m_ready | ~m_valid;

    atan_prep #(.COORD_BITS(COORD_BITS)) u_prep (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(s_valid), .in_ready(s_ready),
        .x_coord(s_x_coord), .y_coord(s_y_coord),
        .out_valid(prep_v), .out_adv(div1_rdy),
        .lo(lo), .hi(hi), .flags(prep_f)
    );

    atan_div #(.DW(COORD_BITS), .SW(ITEM_W)) u_div1 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(prep_v), .in_ready(div1_rdy),
        .num(lo), .den(hi), .side_in(prep_f),
        .out_valid(div1_v), .out_adv(xf_rdy),
        .quo(t), .side_out(div1_side)
    );

    assign div1_f = item_t'(div1_side);

    atan_xform u_xform (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(div1_v), .in_ready(xf_rdy),
        .t(t), .flags_in(div1_f),
        .out_valid(xf_v), .out_adv(div2_rdy),
        .num(xf_num), .den(xf_den), .t_out(xf_t), .flags_out(xf_f)
    );

    atan_div #(.DW(XF_W), .SW(ITEM_W + XM_W)) u_div2 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(xf_v), .in_ready(div2_rdy),
        .num(xf_num), .den(xf_den), .side_in({xf_f, xf_t}),
        .out_valid(div2_v), .out_adv(poly_rdy),
        .quo(xq), .side_out(div2_side)
    );

    atan_poly u_poly (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(div2_v), .in_ready(poly_rdy),
        .xq(xq), .t_in(div2_side[XM_W-1:0]),
        .flags_in(item_t'(div2_side[ITEM_W+XM_W-1:XM_W])),
        .out_valid(poly_v), .out_adv(div3_rdy),
        .num(poly_num), .den(poly_den), .xm_out(poly_xm), .flags_out(poly_f)
    );

    atan_div #(.DW(QM_W), .SW(ITEM_W + XM_W)) u_div3 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(poly_v), .in_ready(div3_rdy),
        .num(poly_num), .den(poly_den), .side_in({poly_f, poly_xm}),
        .out_valid(div3_v), .out_adv(post_rdy),
        .quo(rq), .side_out(div3_side)
    );

    atan_post u_post (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(div3_v), .in_ready(post_rdy),
        .r(rq), .xm_in(div3_side[XM_W-1:0]),
        .flags_in(item_t'(div3_side[ITEM_W+XM_W-1:XM_W])),
        .out_valid(m_valid), .out_adv(m_ready),
        .angle(m_angle)
    );

endmodule

### hdl/atan_div.sv
// pipelined restoring divider: floor(num * 2^30 / den), one quotient bit per stage
module atan_div import atan_pkg::*; #(
    parameter int DW = 32,
    parameter int SW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [DW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    input  logic          out_adv,
    output logic [QW-1:0] quo,
    output logic [SW-1:0] side_out
);

    logic [QW-1:0] v_reg, adv, adv_nx, vin;
    logic [DW-1:0] rem_reg  [QW];
    logic [DW-1:0] rem_next [QW];
    logic [DW-1:0] den_reg  [QW];
    logic [DW-1:0] den_next [QW];
    logic [QW-1:0] quo_reg  [QW];
    logic [QW-1:0] quo_next [QW];
    logic [SW-1:0] side_reg [QW];
    logic [SW-1:0] side_next[QW];

    always_comb begin
        logic [DW:0] r2;
        logic        ge;
        adv    = {QW{en}} | ~v_reg;
        adv_nx = {out_adv, adv[QW-1:1]};
        vin    = {v_reg[QW-2:0], in_valid};
        // top bit: num never exceeds den
        ge           = (num >= den);
        rem_next[0]  = ge ? num - den : num;
        den_next[0]  = den;
        quo_next[0]  = QW'(ge);
        side_next[0] = side_in;
        for (int k = 1; k < QW; k++) begin
            r2           = {rem_reg[k-1], 1'b0};
            ge           = (r2 >= {1'b0, den_reg[k-1]});
            rem_next[k]  = ge ? DW'(r2 - {1'b0, den_reg[k-1]}) : r2[DW-1:0];
            den_next[k]  = den_reg[k-1];
            quo_next[k]  = {quo_reg[k-1][QW-2:0], ge};
            side_next[k] = side_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int k = 0; k < QW; k++) begin
                if (adv[k]) begin
                    v_reg[k] <= vin[k];
                end else if (adv_nx[k]) begin
                    v_reg[k] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < QW; k++) begin
            if (adv[k]) begin
                rem_reg[k]  <= rem_next[k];
                den_reg[k]  <= den_next[k];
                quo_reg[k]  <= quo_next[k];
                side_reg[k] <= side_next[k];
            end
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = v_reg[QW-1];
    assign quo       = quo_reg[QW-1];
    assign side_out  = side_reg[QW-1];

endmodule

### hdl/atan_prep.sv
// input stage: magnitudes, axis flags and ordering of the ratio
module atan_prep import atan_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] x_coord,
    input  logic signed [COORD_BITS-1:0] y_coord,
    output logic                         out_valid,
    input  logic                         out_adv,
    output logic [COORD_BITS-1:0]        lo,
    output logic [COORD_BITS-1:0]        hi,
    output item_t                        flags
);

    logic                  v_reg, adv;
    logic [COORD_BITS-1:0] xu, yu, ax, ay;
    logic [COORD_BITS-1:0] lo_reg, lo_next, hi_reg, hi_next;
    item_t                 flags_reg, flags_next;

    always_comb begin
        adv = en | ~v_reg;
        xu  = x_coord;
        yu  = y_coord;
        ax  = xu[COORD_BITS-1] ? (~xu + 1'b1) : xu;
        ay  = yu[COORD_BITS-1] ? (~yu + 1'b1) : yu;
        flags_next        = '0;
        flags_next.xneg   = xu[COORD_BITS-1];
        flags_next.yneg   = yu[COORD_BITS-1];
        flags_next.x_zero = (ax == '0);
        flags_next.y_zero = (ay == '0);
        flags_next.swap   = (ay > ax);
        lo_next = flags_next.swap ? ax : ay;
        hi_next = flags_next.swap ? ay : ax;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (adv) begin
            v_reg <= in_valid;
        end else if (out_adv) begin
            v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            flags_reg <= flags_next;
        end
    end

    assign in_ready  = adv;
    assign out_valid = v_reg;
    assign lo        = lo_reg;
    assign hi        = hi_reg;
    assign flags     = flags_reg;

endmodule

### hdl/atan_xform.sv
// 2-sqrt(3) reduction: numerator and denominator of (sqrt3*t - 1) / (sqrt3 + t)
module atan_xform import atan_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [QW-1:0]   t,
    input  item_t           flags_in,
    output logic            out_valid,
    input  logic            out_adv,
    output logic [XF_W-1:0] num,
    output logic [XF_W-1:0] den,
    output logic [XM_W-1:0] t_out,
    output item_t           flags_out
);

    localparam int N = 2;

    logic [N-1:0]    v_reg, adv, adv_nx, vin;
    logic [61:0]     prod;
    logic [XF_W-1:0] st1_reg, st1_next, den1_reg, den1_next;
    logic [XM_W-1:0] t1_reg, t2_reg;
    item_t           f1_reg, f1_next, f2_reg, f2_next;
    logic [XF_W-1:0] num2_reg, num2_next, den2_reg;
    logic            ge;

    always_comb begin
        adv    = {N{en}} | ~v_reg;
        adv_nx = {out_adv, adv[N-1:1]};
        vin    = {v_reg[N-2:0], in_valid};
        prod      = ROOT3_K * t;
        st1_next  = prod[61:30];
        den1_next = {1'b0, ROOT3_K} + {1'b0, t};
        f1_next       = flags_in;
        f1_next.xform = (t > TAN15_K);
        // sign and magnitude of sqrt3*t - 1
        ge        = (st1_reg >= QONE_K);
        num2_next = ge ? st1_reg - QONE_K : QONE_K - st1_reg;
        f2_next      = f1_reg;
        f2_next.rneg = f1_reg.xform & ~ge;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int k = 0; k < N; k++) begin
                if (adv[k]) begin
                    v_reg[k] <= vin[k];
                end else if (adv_nx[k]) begin
                    v_reg[k] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            st1_reg  <= st1_next;
            den1_reg <= den1_next;
            t1_reg   <= t[XM_W-1:0];
            f1_reg   <= f1_next;
        end
        if (adv[1]) begin
            num2_reg <= num2_next;
            den2_reg <= den1_reg;
            t2_reg   <= t1_reg;
            f2_reg   <= f2_next;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = v_reg[N-1];
    assign num       = num2_reg;
    assign den       = den2_reg;
    assign t_out     = t2_reg;
    assign flags_out = f2_reg;

endmodule

### hdl/atan_poly.sv
// rational polynomial in g = x^2: horner chains for |P| and Q, then g*|P|
module atan_poly import atan_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [QW-1:0]   xq,
    input  logic [XM_W-1:0] t_in,
    input  item_t           flags_in,
    output logic            out_valid,
    input  logic            out_adv,
    output logic [QM_W-1:0] num,
    output logic [QM_W-1:0] den,
    output logic [XM_W-1:0] xm_out,
    output item_t           flags_out
);

    localparam int N = 5;

    logic [N-1:0]    v_reg, adv, adv_nx, vin;
    logic [XM_W-1:0] xm;
    logic [57:0]     sq;
    logic [56:0]     pm1;
    logic [60:0]     qm1, pm2, pm4;
    logic [62:0]     qm2;
    logic [61:0]     pm3;
    logic [63:0]     qm3;

    logic [G_W-1:0]  g_reg [N-1];
    logic [G_W-1:0]  g_next;
    logic [XM_W-1:0] xm_reg[N];
    item_t           f_reg [N];
    logic [33:0]     gq3_reg, gq3_next;
    logic [33:0]     pa2_reg, pa2_next, pa4_reg, pa4_next;
    logic [34:0]     pa3_reg, pa3_next;
    logic [35:0]     qb2_reg, qb2_next, qb4_reg, qb4_next, qm5_reg;
    logic [36:0]     qb3_reg, qb3_next;
    logic [W_W-1:0]  w_reg, w_next;

    always_comb begin
        adv    = {N{en}} | ~v_reg;
        adv_nx = {out_adv, adv[N-1:1]};
        vin    = {v_reg[N-2:0], in_valid};
        xm       = flags_in.xform ? xq[XM_W-1:0] : t_in;
        sq       = xm * xm;
        g_next   = sq[56:30];
        gq3_next = Q3_K + {7'b0, g_next};
        pm1      = P3_K * g_reg[0];
        pa2_next = {7'b0, pm1[56:30]} + P2_K;
        qm1      = gq3_reg * g_reg[0];
        qb2_next = {5'b0, qm1[60:30]} + Q2_K;
        pm2      = pa2_reg * g_reg[1];
        pa3_next = {4'b0, pm2[60:30]} + P1_K;
        qm2      = qb2_reg * g_reg[1];
        qb3_next = {4'b0, qm2[62:30]} + Q1_K;
        pm3      = pa3_reg * g_reg[2];
        pa4_next = {2'b0, pm3[61:30]} + P0_K;
        qm3      = qb3_reg * g_reg[2];
        qb4_next = {2'b0, qm3[63:30]} + Q0_K;
        pm4      = g_reg[3] * pa4_reg;
        w_next   = pm4[60:30];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int k = 0; k < N; k++) begin
                if (adv[k]) begin
                    v_reg[k] <= vin[k];
                end else if (adv_nx[k]) begin
                    v_reg[k] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            g_reg[0]  <= g_next;
            gq3_reg   <= gq3_next;
            xm_reg[0] <= xm;
            f_reg[0]  <= flags_in;
        end
        if (adv[1]) begin
            pa2_reg <= pa2_next;
            qb2_reg <= qb2_next;
        end
        if (adv[2]) begin
            pa3_reg <= pa3_next;
            qb3_reg <= qb3_next;
        end
        if (adv[3]) begin
            pa4_reg <= pa4_next;
            qb4_reg <= qb4_next;
        end
        if (adv[4]) begin
            w_reg   <= w_next;
            qm5_reg <= qb4_reg;
        end
        for (int k = 1; k < N; k++) begin
            if (adv[k]) begin
                xm_reg[k] <= xm_reg[k-1];
                f_reg[k]  <= f_reg[k-1];
            end
        end
        for (int k = 1; k < N - 1; k++) begin
            if (adv[k]) begin
                g_reg[k] <= g_reg[k-1];
            end
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = v_reg[N-1];
    assign num       = {5'b0, w_reg};
    assign den       = qm5_reg;
    assign xm_out    = xm_reg[N-1];
    assign flags_out = f_reg[N-1];

endmodule

### hdl/atan_post.sv
// correction, octant offset, quadrant fix, axis cases, rounding to q13 and output register
module atan_post import atan_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [QW-1:0]             r,
    input  logic [XM_W-1:0]           xm_in,
    input  item_t                     flags_in,
    output logic                      out_valid,
    input  logic                      out_adv,
    output logic signed [ANGLE_W-1:0] angle
);

    localparam int N = 5;

    logic [N-1:0]               v_reg, adv, adv_nx, vin;
    logic [59:0]                cp;
    logic [29:0]                corr_reg, corr_next;
    logic [XM_W-1:0]            xm1_reg, m;
    item_t                      f1_reg, f2_reg;
    logic signed [V_W-1:0]      off, msx, adj;
    logic signed [V_W-1:0]      v2_reg, v2_next, v3_reg, v3_next;
    logic                       neg4_reg;
    logic [V_W-2:0]             mag4_reg, mag4_next;
    logic [V_W-1:0]             rnd;
    logic [16:0]                rq, sat;
    logic signed [ANGLE_W-1:0]  angle_reg, angle_next;

    always_comb begin
        adv    = {N{en}} | ~v_reg;
        adv_nx = {out_adv, adv[N-1:1]};
        vin    = {v_reg[N-2:0], in_valid};
        cp        = xm_in * r;
        corr_next = cp[59:30];
        // x - x*R, clamped at zero
        m       = (corr_reg <= {1'b0, xm1_reg}) ? XM_W'({1'b0, xm1_reg} - corr_reg) : '0;
        msx     = $signed({5'b0, m});
        off     = oct_offset({f1_reg.swap, f1_reg.xform});
        v2_next = (f1_reg.rneg ^ f1_reg.swap) ? off - msx : off + msx;
        adj     = f2_reg.xneg ? (f2_reg.yneg ? -PI_S : PI_S) : '0;
        priority if (f2_reg.x_zero && f2_reg.y_zero) begin
            v3_next = '0;
        end else if (f2_reg.x_zero) begin
            v3_next = f2_reg.yneg ? -PI2_S : PI2_S;
        end else if (f2_reg.y_zero) begin
            v3_next = f2_reg.xneg ? PI_S : '0;
        end else begin
            v3_next = (f2_reg.xneg ^ f2_reg.yneg) ? adj - v2_reg : adj + v2_reg;
        end
        mag4_next  = v3_reg[V_W-1] ? (V_W-1)'(-v3_reg) : v3_reg[V_W-2:0];
        // round half away from zero, then clamp to pi
        rnd        = {1'b0, mag4_reg} + (V_W'(1) << 16);
        rq         = rnd[V_W-1:17];
        sat        = (rq > 17'(ANGLE_MAX)) ? 17'(ANGLE_MAX) : rq;
        angle_next = neg4_reg ? -$signed(sat[ANGLE_W-1:0]) : $signed(sat[ANGLE_W-1:0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int k = 0; k < N; k++) begin
                if (adv[k]) begin
                    v_reg[k] <= vin[k];
                end else if (adv_nx[k]) begin
                    v_reg[k] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            corr_reg <= corr_next;
            xm1_reg  <= xm_in;
            f1_reg   <= flags_in;
        end
        if (adv[1]) begin
            v2_reg <= v2_next;
            f2_reg <= f1_reg;
        end
        if (adv[2]) begin
            v3_reg <= v3_next;
        end
        if (adv[3]) begin
            mag4_reg <= mag4_next;
            neg4_reg <= v3_reg[V_W-1];
        end
        if (adv[4]) begin
            angle_reg <= angle_next;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = v_reg[N-1];
    assign angle     = angle_reg;

endmodule

### hdl/atan_check.sv
// port checker for the atan2 angle unit and its bind
`include "atan2_angle_unit_assert.svh"

module atan_check import atan_pkg::*; (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic signed [ANGLE_W-1:0] m_angle
);

    `ATAN_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "result valid after reset")
    `ATAN_ASSERT(a_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_angle), "stalled result changed")
    `ATAN_ASSERT(a_range, aclk, aresetn, m_valid |-> m_angle >= -16'sd25736 && m_angle <= 16'sd25736, "angle out of range")
    `ATAN_ASSERT(a_ready_empty, aclk, aresetn, !m_valid |-> s_ready, "input blocked with empty output")

endmodule

bind atan2_angle_unit atan_check u_check (
    .aclk(aclk), .aresetn(aresetn),
    .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_angle(m_angle)
);
